@@ rtl/core/sfpd_pkg.sv @@
`timescale 1ns / 1ps

package sfpd_pkg;

  // Stream commands carried in tuser of the input channel
  localparam logic [1:0] CMD_DATA  = 2'd0;
  localparam logic [1:0] CMD_ABORT = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_START_LEN = 2'd0;
  localparam logic [1:0] REG_END_LEN   = 2'd1;
  localparam logic [1:0] REG_WORDS     = 2'd2;
  localparam logic [1:0] REG_MAX_JUMP  = 2'd3;

  localparam int unsigned CFG_W   = 31;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned OUT_W   = 8 + 8 * CNT_W;

  localparam logic [5:0]  START_LEN_RST = 6'd16;
  localparam logic [5:0]  END_LEN_RST   = 6'd8;
  localparam logic [9:0]  WORDS_RST     = 10'd180;
  localparam logic [30:0] MAX_JUMP_RST  = 31'd200000;

  localparam logic [7:0]  MARKER_BYTE   = 8'hFF;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_SEQA  = 3'd1,
    PH_SEQB  = 3'd2,
    PH_LANEA = 3'd3,
    PH_LANEB = 3'd4,
    PH_ENDM  = 3'd5
  } phase_e;

  // A marker length of zero behaves as one
  function automatic logic [5:0] eff_len(input logic [5:0] len);
    eff_len = (len == 6'd0) ? 6'd1 : len;
  endfunction

endpackage

@@ rtl/core/sync_framed_packet_deframer.sv @@
`timescale 1ns / 1ps

// Framed packet deframer.
// Input channel (s_axis_*): one word per stream byte; tdata carries the byte,
// tuser the command (data byte, abort to hunting, clear counters).
// Output channel (m_axis_*): exactly one word per input word, in order. tuser
// flags whether the byte is lane payload and which lane; tdata carries the lane
// byte (zero otherwise), the seven statistics counters after this word and the last sequence A.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at the
// clock edge (start marker length, end marker length, words per packet,
// largest trusted sequence jump); write only while the block is idle.
// Each accepted word is registered in the input register and then in the result register.
// Throughput: one word per cycle while the receiver is ready; the input register
// feeds the phase and counter update logic that loads the result register directly.
// When the receiver stalls, the result register holds, the input register
// fills, and s_axis_tready drops; nothing is lost.
// Reset clears phase, counters and sequence state and loads the register
// defaults; the block is ready to accept a word straight out of reset.
module sync_framed_packet_deframer #(
  parameter int unsigned LANE_BYTES = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] in_byte
  input  logic [1:0]                s_axis_tuser,   // [1:0] cmd
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [7:0] lane_byte, [39:8] sync_count, [71:40] search_count,
  // [103:72] word_count, [135:104] good_packet_count,
  // [167:136] lost_packet_count, [199:168] mismatch_count,
  // [231:200] end_error_count, [263:232] last_seq_a
  output logic [sfpd_pkg::OUT_W-1:0] m_axis_tdata,
  output logic [1:0]                m_axis_tuser,   // [0] lane_valid, [1] lane_select
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [sfpd_pkg::CFG_W-1:0] cfg_wdata_i
);
  import sfpd_pkg::*;

  localparam int unsigned LbW = (LANE_BYTES > 1) ? $clog2(LANE_BYTES) : 1;
  localparam logic [LbW-1:0] LANE_LAST = LbW'(LANE_BYTES - 1);

  // Configuration registers
  logic [5:0]  start_len_q, end_len_q;
  logic [9:0]  words_q;
  logic [30:0] max_jump_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_len_q <= START_LEN_RST;
      end_len_q   <= END_LEN_RST;
      words_q     <= WORDS_RST;
      max_jump_q  <= MAX_JUMP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START_LEN: start_len_q <= cfg_wdata_i[5:0];
        REG_END_LEN:   end_len_q   <= cfg_wdata_i[5:0];
        REG_WORDS:     words_q     <= cfg_wdata_i[9:0];
        REG_MAX_JUMP:  max_jump_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register
  logic       in_valid_q;
  logic [1:0] cmd_q;
  logic [7:0] byte_q;
  logic       out_valid_q;
  logic       adv;
  logic       proc;

  assign adv           = !out_valid_q || m_axis_tready;
  assign proc          = in_valid_q && adv;
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q  <= s_axis_tuser;
      byte_q <= s_axis_tdata;
    end
  end

  // Deframer state; counters double as the result register
  phase_e          phase_q, phase_d;
  logic [5:0]      marker_run_q, marker_run_d;
  logic [LbW-1:0]  lane_idx_q, lane_idx_d;
  logic [9:0]      word_idx_q, word_idx_d;
  logic [31:0]     seq_a_q, seq_a_d, seq_b_q, seq_b_d, prev_q, prev_d;
  logic [31:0]     sync_cnt_q, sync_cnt_d, search_cnt_q, search_cnt_d;
  logic [31:0]     word_cnt_q, word_cnt_d, good_cnt_q, good_cnt_d;
  logic [31:0]     lost_cnt_q, lost_cnt_d, mism_cnt_q, mism_cnt_d;
  logic [31:0]     enderr_cnt_q, enderr_cnt_d;
  logic            lane_valid_q, lane_valid_d, lane_sel_q, lane_sel_d;
  logic [7:0]      lane_byte_q, lane_byte_d;

  logic [31:0] jump;
  logic [31:0] lost_inc;
  logic [5:0]  run_inc;
  logic [9:0]  word_inc;

  always_comb begin
    jump = seq_a_q - prev_q;
    if (jump[31] || (jump[30:0] > max_jump_q)) begin
      lost_inc = 32'd1;
    end else if (jump == 32'd0) begin
      lost_inc = 32'd0;
    end else begin
      lost_inc = jump - 32'd1;
    end
  end

  assign run_inc  = marker_run_q + 6'd1;
  assign word_inc = word_idx_q + 10'd1;

  always_comb begin
    phase_d      = phase_q;
    marker_run_d = marker_run_q;
    lane_idx_d   = lane_idx_q;
    word_idx_d   = word_idx_q;
    seq_a_d      = seq_a_q;
    seq_b_d      = seq_b_q;
    prev_d       = prev_q;
    sync_cnt_d   = sync_cnt_q;
    search_cnt_d = search_cnt_q;
    word_cnt_d   = word_cnt_q;
    good_cnt_d   = good_cnt_q;
    lost_cnt_d   = lost_cnt_q;
    mism_cnt_d   = mism_cnt_q;
    enderr_cnt_d = enderr_cnt_q;
    lane_valid_d = 1'b0;
    lane_sel_d   = 1'b0;
    lane_byte_d  = 8'd0;

    unique case (cmd_q)
      CMD_ABORT: begin
        phase_d      = PH_HUNT;
        marker_run_d = 6'd0;
        lane_idx_d   = '0;
      end
      CMD_CLEAR: begin
        sync_cnt_d   = 32'd0;
        search_cnt_d = 32'd0;
        word_cnt_d   = 32'd0;
        good_cnt_d   = 32'd0;
        lost_cnt_d   = 32'd0;
        mism_cnt_d   = 32'd0;
        enderr_cnt_d = 32'd0;
        prev_d       = 32'd0;
      end
      CMD_DATA: begin
        unique case (phase_q)
          PH_SEQA: begin
            seq_a_d      = {seq_a_q[23:0], byte_q};
            marker_run_d = run_inc;
            if (marker_run_q >= 6'd3) begin
              phase_d      = PH_SEQB;
              marker_run_d = 6'd0;
            end
          end
          PH_SEQB: begin
            seq_b_d      = {seq_b_q[23:0], byte_q};
            marker_run_d = run_inc;
            if (marker_run_q >= 6'd3) begin
              // close the header: lost and mismatch accounting
              lost_cnt_d   = lost_cnt_q + lost_inc;
              prev_d       = seq_a_q;
              if (seq_a_q != {seq_b_q[23:0], byte_q}) begin
                mism_cnt_d = mism_cnt_q + 32'd1;
              end
              phase_d      = PH_LANEA;
              marker_run_d = 6'd0;
              lane_idx_d   = '0;
              word_idx_d   = 10'd0;
            end
          end
          PH_LANEA: begin
            lane_valid_d = 1'b1;
            lane_byte_d  = byte_q;
            lane_idx_d   = lane_idx_q + LbW'(1);
            if (lane_idx_q == LANE_LAST) begin
              phase_d    = PH_LANEB;
              lane_idx_d = '0;
            end
          end
          PH_LANEB: begin
            lane_valid_d = 1'b1;
            lane_sel_d   = 1'b1;
            lane_byte_d  = byte_q;
            lane_idx_d   = lane_idx_q + LbW'(1);
            if (lane_idx_q == LANE_LAST) begin
              lane_idx_d = '0;
              word_cnt_d = word_cnt_q + 32'd1;
              word_idx_d = word_inc;
              if (word_inc == words_q) begin
                phase_d      = PH_ENDM;
                marker_run_d = 6'd0;
              end else begin
                phase_d = PH_LANEA;
              end
            end
          end
          PH_ENDM: begin
            if (byte_q == MARKER_BYTE) begin
              marker_run_d = run_inc;
              if (run_inc == eff_len(end_len_q)) begin
                good_cnt_d   = good_cnt_q + 32'd1;
                phase_d      = PH_HUNT;
                marker_run_d = 6'd0;
              end
            end else begin
              // bad end byte: count it, then rescan it as a hunting byte
              enderr_cnt_d = enderr_cnt_q + 32'd1;
              search_cnt_d = search_cnt_q + 32'd1;
              phase_d      = PH_HUNT;
              marker_run_d = 6'd0;
            end
          end
          default: begin
            phase_d = PH_HUNT;
            if (byte_q == MARKER_BYTE) begin
              marker_run_d = run_inc;
              if (run_inc == eff_len(start_len_q)) begin
                sync_cnt_d   = sync_cnt_q + 32'd1;
                phase_d      = PH_SEQA;
                marker_run_d = 6'd0;
              end
            end else begin
              search_cnt_d = search_cnt_q + 32'd1;
              marker_run_d = 6'd0;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      phase_q      <= PH_HUNT;
      marker_run_q <= 6'd0;
      lane_idx_q   <= '0;
      word_idx_q   <= 10'd0;
      seq_a_q      <= 32'd0;
      seq_b_q      <= 32'd0;
      prev_q       <= 32'd0;
      sync_cnt_q   <= 32'd0;
      search_cnt_q <= 32'd0;
      word_cnt_q   <= 32'd0;
      good_cnt_q   <= 32'd0;
      lost_cnt_q   <= 32'd0;
      mism_cnt_q   <= 32'd0;
      enderr_cnt_q <= 32'd0;
      lane_valid_q <= 1'b0;
      lane_sel_q   <= 1'b0;
      lane_byte_q  <= 8'd0;
    end else begin
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
      if (proc) begin
        phase_q      <= phase_d;
        marker_run_q <= marker_run_d;
        lane_idx_q   <= lane_idx_d;
        word_idx_q   <= word_idx_d;
        seq_a_q      <= seq_a_d;
        seq_b_q      <= seq_b_d;
        prev_q       <= prev_d;
        sync_cnt_q   <= sync_cnt_d;
        search_cnt_q <= search_cnt_d;
        word_cnt_q   <= word_cnt_d;
        good_cnt_q   <= good_cnt_d;
        lost_cnt_q   <= lost_cnt_d;
        mism_cnt_q   <= mism_cnt_d;
        enderr_cnt_q <= enderr_cnt_d;
        lane_valid_q <= lane_valid_d;
        lane_sel_q   <= lane_sel_d;
        lane_byte_q  <= lane_byte_d;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = {lane_sel_q, lane_valid_q};
  assign m_axis_tdata  = {prev_q, enderr_cnt_q, mism_cnt_q, lost_cnt_q,
                          good_cnt_q, word_cnt_q, search_cnt_q, sync_cnt_q,
                          lane_byte_q};

  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && (cmd_q == CMD_CLEAR) |=>
      (sync_cnt_q == 32'd0) && (search_cnt_q == 32'd0) && (word_cnt_q == 32'd0) &&
      (good_cnt_q == 32'd0) && (lost_cnt_q == 32'd0) && (mism_cnt_q == 32'd0) &&
      (enderr_cnt_q == 32'd0) && (prev_q == 32'd0))
    else $error("clear command left a counter nonzero");

  a_abort_hunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && (cmd_q == CMD_ABORT) |=> (phase_q == PH_HUNT) && (marker_run_q == 6'd0))
    else $error("abort did not return to hunting");

  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !lane_valid_q |-> !lane_sel_q && (lane_byte_q == 8'd0))
    else $error("lane fields set without payload");

  a_word_only_laneb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && (cmd_q == CMD_DATA) && (phase_q != PH_LANEB) |=>
      word_cnt_q == $past(word_cnt_q))
    else $error("word count moved outside lane B");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !proc |=> $stable(phase_q) && $stable(sync_cnt_q) && $stable(lane_byte_q))
    else $error("state changed without a word being processed");

endmodule
